FILE: hw/rtl/wlgm_pkg.sv
package wlgm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int RAW_W   = 16;
    localparam int SLOPE_W = 16;
    localparam int ICPT_W  = 16;
    localparam int CTR_W   = 24;
    localparam int WID_W   = 24;
    localparam int GREY_W  = 8;
    localparam int Q_W     = GREY_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ICPT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(3);

    localparam logic [SLOPE_W-1:0]       SLOPE_RST  = 16'd256;
    localparam logic signed [ICPT_W-1:0] ICPT_RST   = 16'sd0;
    localparam logic signed [CTR_W-1:0]  CENTER_RST = 24'sd524288;
    localparam logic [WID_W-1:0]         WIDTH_RST  = 24'd1048576;

    // 1.0 in Q8
    localparam logic [WID_W-1:0] ONE_Q8 = WID_W'(256);

    // window edges (doubled Q8), doubled window span, divider dividend
    localparam int EDGE_W = 27;
    localparam int NUM_W  = 25;
    localparam int DVD_W  = NUM_W + GREY_W;

    localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

    typedef struct packed {
        logic [DVD_W-1:0] dvd;
        logic [NUM_W-1:0] dvs;
        logic             sat_lo;
        logic             sat_hi;
    } t_div_in;

endpackage

FILE: hw/rtl/window_level_grey_map_top.sv
// Window/level grey mapper: raw scanner sample in, 8-bit display grey level out.
//
// Input channel: i_valid / o_stall with i_raw_sample; a transaction happens at a
// clock edge with i_valid high and o_stall low. Only the low SAMPLE_BITS bits of
// the sample count. Output channel: o_valid / i_stall with o_grey_level, one
// result per input transaction, in order.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_addr
// (0 slope, 1 intercept, 2 center, 3 width); write only while the pipe is empty.
// Datapath: rescale, edge compare and dividend forming, then 8 stages of a
// restoring divider, one quotient bit each. Throughput: one transaction per
// clock while the output is not stalled.
// A stalled receiver holds the output register; stages upstream keep moving
// into empty slots, and o_stall rises only when every stage is full.
// Reset (synchronous, active low) empties the pipe and loads the register
// defaults: slope 1.0, intercept 0, center 2048.0, width 4096.0.
module window_level_grey_map_top #(
    parameter int SAMPLE_BITS = wlgm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [wlgm_pkg::RAW_W-1:0]        i_raw_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [wlgm_pkg::GREY_W-1:0]       o_grey_level,
    input  logic                              i_cfg_wr_en,
    input  logic [wlgm_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [wlgm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import wlgm_pkg::*;

    localparam int PW = SAMPLE_BITS + SLOPE_W;
    localparam int CW = PW + 3;

    logic [SLOPE_W-1:0]       r_slope;
    logic signed [ICPT_W-1:0] r_icpt;
    logic signed [CTR_W-1:0]  r_center;
    logic [WID_W-1:0]         r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= SLOPE_RST;
            r_icpt   <= ICPT_RST;
            r_center <= CENTER_RST;
            r_width  <= WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SLOPE:  r_slope  <= i_cfg_wdata[SLOPE_W-1:0];
                CFG_ICPT:   r_icpt   <= i_cfg_wdata[ICPT_W-1:0];
                CFG_CENTER: r_center <= i_cfg_wdata[CTR_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_wdata[WID_W-1:0];
                default: ;
            endcase
        end
    end

    // window edges, doubled Q8; registered from the config registers
    logic [WID_W-1:0]         w_eff;
    logic [WID_W-1:0]         w1;
    logic signed [EDGE_W-1:0] n_lo2;
    logic signed [EDGE_W-1:0] n_hi2;
    logic signed [EDGE_W-1:0] r_lo2;
    logic signed [EDGE_W-1:0] r_hi2;
    logic [NUM_W-1:0]         r_dvs;
    logic                     r_wz;

    always_comb begin
        w_eff = (r_width < ONE_Q8) ? ONE_Q8 : r_width;
        w1    = w_eff - ONE_Q8;
        n_lo2 = (EDGE_W'(r_center) <<< 1) - EDGE_W'(signed'(ONE_Q8))
              - signed'(EDGE_W'(w1));
        n_hi2 = (EDGE_W'(r_center) <<< 1) - EDGE_W'(signed'(ONE_Q8))
              + signed'(EDGE_W'(w1));
    end

    always_ff @(posedge i_clk) begin
        r_lo2 <= n_lo2;
        r_hi2 <= n_hi2;
        r_dvs <= {w1, 1'b0};
        r_wz  <= (w1 == '0);
    end

    // stage handshake: a stage loads when empty or when the next one loads
    logic en1, en2, en3, en4, div_rdy;
    logic r_v1, r_v2, r_v3, r_v4;

    assign en4 = !r_v4 || div_rdy;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 1: slope * sample
    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_prod <= PW'(r_slope) * PW'(i_raw_sample[SAMPLE_BITS-1:0]);
        end
    end

    // stage 2: 2x in Q8
    logic signed [CW-1:0] n_x2;
    logic signed [CW-1:0] r_x2;

    always_comb begin
        n_x2 = (signed'(CW'(r_prod)) + (CW'(r_icpt) <<< 8)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_x2 <= n_x2;
        end
    end

    // stage 3: edge compares and offset above the low edge
    logic                 n_slo3, n_shi3;
    logic signed [CW-1:0] lo2_x, hi2_x, diff;
    logic [NUM_W-1:0]     r_num;
    logic                 r_slo3, r_shi3;

    always_comb begin
        lo2_x  = CW'(r_lo2);
        hi2_x  = CW'(r_hi2);
        diff   = r_x2 - lo2_x;
        n_slo3 = (r_x2 <= lo2_x);
        n_shi3 = !n_slo3 && ((r_x2 > hi2_x) || r_wz);
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_num  <= diff[NUM_W-1:0];
            r_slo3 <= n_slo3;
            r_shi3 <= n_shi3;
        end
    end

    // stage 4: dividend num * 255
    t_div_in r_div4;

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            r_div4.dvd    <= {r_num, GREY_W'(0)} - DVD_W'(r_num);
            r_div4.dvs    <= r_dvs;
            r_div4.sat_lo <= r_slo3;
            r_div4.sat_hi <= r_shi3;
        end
    end

    wlgm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_div   (r_div4),
        .o_ready (div_rdy),
        .o_valid (o_valid),
        .o_grey  (o_grey_level),
        .i_stall (i_stall)
    );

    a_sat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> !(r_slo3 && r_shi3))
        else $error("both saturation flags set");

    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_slo3 && !r_shi3 |-> r_num != '0 && r_num <= r_dvs)
        else $error("offset outside the window span");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !en2 |=> r_v1 && $stable(r_prod))
        else $error("stage 1 lost a held transaction");

endmodule

FILE: hw/rtl/wlgm_div.sv
module wlgm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  wlgm_pkg::t_div_in             i_div,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [wlgm_pkg::GREY_W-1:0]   o_grey,
    input  logic                          i_stall
);
    import wlgm_pkg::*;

    localparam int STAGES = Q_W;

    logic             r_v   [STAGES];
    logic [DVD_W-1:0] r_rem [STAGES];
    logic [Q_W-1:0]   r_q   [STAGES];
    logic [NUM_W-1:0] r_dvs [STAGES];
    logic             r_slo [STAGES];
    logic             r_shi [STAGES];
    logic             rdy   [STAGES];

    // one quotient bit per stage, MSB first; last stage is the output register
    for (genvar j = 0; j < STAGES; j++) begin : g_stg
        localparam int SH = STAGES - 1 - j;

        logic             v_in;
        logic [DVD_W-1:0] rem_in;
        logic [Q_W-1:0]   q_in;
        logic [NUM_W-1:0] dvs_in;
        logic             slo_in;
        logic             shi_in;
        logic [DVD_W-1:0] sub;
        logic [DVD_W-1:0] n_rem;
        logic [Q_W-1:0]   n_q;
        logic             bit_set;

        if (j == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_div.dvd;
            assign q_in   = '0;
            assign dvs_in = i_div.dvs;
            assign slo_in = i_div.sat_lo;
            assign shi_in = i_div.sat_hi;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign dvs_in = r_dvs[j-1];
            assign slo_in = r_slo[j-1];
            assign shi_in = r_shi[j-1];
        end

        if (j == STAGES - 1) begin : g_rdy_last
            assign rdy[j] = !r_v[j] || !i_stall;
        end else begin : g_rdy_mid
            assign rdy[j] = !r_v[j] || rdy[j+1];
        end

        always_comb begin
            sub     = DVD_W'(dvs_in) << SH;
            bit_set = (rem_in >= sub);
            n_rem   = bit_set ? (rem_in - sub) : rem_in;
            n_q     = q_in;
            n_q[SH] = bit_set;
            if (j == STAGES - 1) begin
                if (slo_in) begin
                    n_q = '0;
                end else if (shi_in) begin
                    n_q = GREY_MAX;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[j] && v_in) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_dvs[j] <= dvs_in;
                r_slo[j] <= slo_in;
                r_shi[j] <= shi_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[STAGES-1];
    assign o_grey  = r_q[STAGES-1];

    for (genvar j = 0; j < STAGES - 1; j++) begin : g_chk
        localparam int SH = STAGES - 1 - j;

        a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[j] && !rdy[j+1] |=> r_v[j] && $stable(r_rem[j]) && $stable(r_q[j]))
            else $error("divider stage dropped a held transaction");

        a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[j] && !r_slo[j] && !r_shi[j] |-> r_rem[j] < (DVD_W'(r_dvs[j]) << SH))
            else $error("divider remainder out of range");

        a_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[j] |-> r_q[j][SH-1:0] == '0)
            else $error("quotient bit set ahead of its stage");
    end

endmodule
